[hw/rtl/lph_pkg.sv]
package lph_pkg;

	localparam int KEY_W          = 32;
	localparam int SLOTS_DEF      = 256;
	localparam int VALUE_BITS_DEF = 32;

	localparam logic [31:0] HASH_MUL   = 32'h045d_9f3b;
	localparam int          HASH_SHIFT = 16;

	// operation codes
	localparam logic [1:0] MODE_INSERT = 2'd0;
	localparam logic [1:0] MODE_LOOKUP = 2'd1;
	localparam logic [1:0] MODE_REMOVE = 2'd2;

	// result codes
	localparam logic [1:0] STAT_DONE     = 2'd0;
	localparam logic [1:0] STAT_NOTFOUND = 2'd1;
	localparam logic [1:0] STAT_FULL     = 2'd2;

	typedef struct packed {
		logic [1:0]       mode;
		logic [KEY_W-1:0] key;
		logic [31:0]      value_in;
	} in_beat_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [31:0] value_out;
		logic        replaced;
		logic [8:0]  entry_count;
	} out_beat_t;

	// xor-fold step of the key mixer
	function automatic logic [31:0] hash_fold(input logic [31:0] x);
		return x ^ (x >> HASH_SHIFT);
	endfunction

endpackage

[hw/rtl/lph_ram.sv]
module lph_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

[hw/rtl/linear_probe_hash_table_unit.sv]
// Open-addressing hash table of SLOTS entries (power of two), each a 32-bit
// key and a VALUE_BITS-bit value, probed linearly from the home slot given by
// a multiply-xorshift hash of the key. One operation is in flight at a time:
// in_stall stays high from acceptance until the result is loaded into the
// output register. The table lives in a single-port-read, single-port-write
// RAM, so each probe takes a read state and a check state (S_PRD, S_PCHK).
// Hashing (S_HASH1 to S_HASH3) reuses one 32x32 multiplier for both rounds.
// Remove also walks the cluster that follows the freed slot: it checks each
// slot until a free one ends the cluster, and lifts each entry it finds out
// and re-inserts it with a full probe. A stalled result beat holds the block
// in its final state (S_FIN) until the previous beat leaves.
// After reset the occupied marks are cleared by a pass over all SLOTS
// entries, during which no beat is accepted.
module linear_probe_hash_table_unit #(
	parameter int SLOTS      = lph_pkg::SLOTS_DEF,
	parameter int VALUE_BITS = lph_pkg::VALUE_BITS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  lph_pkg::in_beat_t  in_data,
	output logic             out_valid,
	input  logic             out_stall,
	output lph_pkg::out_beat_t out_data
);

	localparam int AW  = $clog2(SLOTS);
	localparam int CNW = AW + 1;              // probe / walk counters reach SLOTS
	localparam int CW  = $clog2(SLOTS + 1);   // occupied count
	localparam int KW  = lph_pkg::KEY_W;
	localparam int EW  = 1 + KW + VALUE_BITS; // ram entry: {used, key, value}

	typedef enum logic [3:0] {
		S_CLEAR, S_IDLE, S_HASH1, S_HASH2, S_HASH3,
		S_PRD, S_PCHK, S_WRD, S_WCHK, S_FIN
	} state_t;

	// what the probe sequence is doing
	typedef enum logic [1:0] {
		PH_INSERT, PH_LOOKUP, PH_FIND, PH_REPUT
	} phase_t;

	state_t                state_q;
	phase_t                ph_q;
	logic [KW-1:0]         key_q;
	logic [VALUE_BITS-1:0] val_q;
	logic [31:0]           h_q;
	logic [AW-1:0]         idx_q;
	logic [CNW-1:0]        pn_q;
	logic [AW-1:0]         j_q;
	logic [CNW-1:0]        wn_q;
	logic [CW-1:0]         count_q;
	logic [AW-1:0]         clr_q;
	logic [1:0]            st_q;
	logic [31:0]           vo_q;
	logic                  rp_q;
	logic                  out_valid_q;
	lph_pkg::out_beat_t    out_data_q;

	// ram ports
	logic                  ram_we;
	logic [AW-1:0]         ram_waddr;
	logic [EW-1:0]         ram_wdata;
	logic [AW-1:0]         ram_raddr;
	logic [EW-1:0]         ram_rdata;

	logic                  r_used;
	logic [KW-1:0]         r_key;
	logic [VALUE_BITS-1:0] r_val;
	logic                  r_hit;
	logic [31:0]           mul_src;
	logic [31:0]           mul_res;
	logic [CW-1:0]         count_dec;

	lph_ram #(
		.WIDTH(EW),
		.DEPTH(SLOTS)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	assign r_used = ram_rdata[EW-1];
	assign r_key  = ram_rdata[VALUE_BITS +: KW];
	assign r_val  = ram_rdata[VALUE_BITS-1:0];
	assign r_hit  = r_used && (r_key == key_q);

	// shared multiplier: first round on the key, second on the first product
	assign mul_src = (state_q == S_HASH1) ? key_q : h_q;
	assign mul_res = lph_pkg::hash_fold(mul_src) * lph_pkg::HASH_MUL;

	assign count_dec = (count_q != '0) ? count_q - CW'(1) : count_q;

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = idx_q;
		ram_wdata = '0;
		ram_raddr = idx_q;
		case (state_q)
			S_CLEAR: begin
				// wipe the occupied marks
				ram_we    = 1'b1;
				ram_waddr = clr_q;
			end
			S_PCHK: begin
				if (!r_used && (ph_q == PH_INSERT || ph_q == PH_REPUT)) begin
					ram_we    = 1'b1;
					ram_wdata = {1'b1, key_q, val_q};
				end else if (r_hit && (ph_q == PH_INSERT || ph_q == PH_REPUT)) begin
					ram_we    = 1'b1;
					ram_wdata = {1'b1, key_q, val_q};
				end else if (r_hit && ph_q == PH_FIND) begin
					// free the slot of the removed key
					ram_we = 1'b1;
				end
			end
			S_WRD: begin
				ram_raddr = j_q + AW'(1);
			end
			S_WCHK: begin
				// lift the cluster entry out before placing it again
				if (r_used) begin
					ram_we    = 1'b1;
					ram_waddr = j_q;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			ph_q        <= PH_INSERT;
			clr_q       <= '0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// load a new result beat, or drop the one that just left
			if (state_q == S_FIN && (!out_valid_q || !out_stall)) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == '1) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (in_valid) begin
						key_q <= in_data.key;
						val_q <= VALUE_BITS'(in_data.value_in);
						vo_q  <= '0;
						rp_q  <= 1'b0;
						st_q  <= lph_pkg::STAT_DONE;
						case (in_data.mode)
							lph_pkg::MODE_INSERT: begin
								if (count_q >= CW'(SLOTS)) begin
									st_q    <= lph_pkg::STAT_FULL;
									state_q <= S_FIN;
								end else begin
									ph_q    <= PH_INSERT;
									state_q <= S_HASH1;
								end
							end
							lph_pkg::MODE_LOOKUP: begin
								ph_q    <= PH_LOOKUP;
								state_q <= S_HASH1;
							end
							lph_pkg::MODE_REMOVE: begin
								ph_q    <= PH_FIND;
								state_q <= S_HASH1;
							end
							default: begin
								st_q    <= lph_pkg::STAT_NOTFOUND;
								state_q <= S_FIN;
							end
						endcase
					end
				end
				S_HASH1: begin
					h_q     <= mul_res;
					state_q <= S_HASH2;
				end
				S_HASH2: begin
					h_q     <= mul_res;
					state_q <= S_HASH3;
				end
				S_HASH3: begin
					idx_q   <= AW'(lph_pkg::hash_fold(h_q));
					pn_q    <= '0;
					state_q <= S_PRD;
				end
				S_PRD: begin
					state_q <= S_PCHK;
				end
				S_PCHK: begin
					if (!r_used) begin
						case (ph_q)
							PH_INSERT: begin
								count_q <= count_q + CW'(1);
								state_q <= S_FIN;
							end
							PH_REPUT: begin
								count_q <= count_q + CW'(1);
								state_q <= S_WRD;
							end
							default: begin
								st_q    <= lph_pkg::STAT_NOTFOUND;
								state_q <= S_FIN;
							end
						endcase
					end else if (r_hit) begin
						case (ph_q)
							PH_INSERT: begin
								rp_q    <= 1'b1;
								state_q <= S_FIN;
							end
							PH_REPUT: begin
								state_q <= S_WRD;
							end
							PH_LOOKUP: begin
								vo_q    <= 32'(r_val);
								state_q <= S_FIN;
							end
							default: begin
								// removal: start the cluster walk after the hole
								count_q <= count_dec;
								j_q     <= idx_q;
								wn_q    <= CNW'(1);
								state_q <= S_WRD;
							end
						endcase
					end else if (pn_q + CNW'(1) == CNW'(SLOTS)) begin
						// went once round the table
						case (ph_q)
							PH_INSERT: state_q <= S_FIN;
							PH_REPUT:  state_q <= S_WRD;
							default: begin
								st_q    <= lph_pkg::STAT_NOTFOUND;
								state_q <= S_FIN;
							end
						endcase
					end else begin
						pn_q    <= pn_q + CNW'(1);
						idx_q   <= idx_q + AW'(1);
						state_q <= S_PRD;
					end
				end
				S_WRD: begin
					if (wn_q == CNW'(SLOTS)) begin
						state_q <= S_FIN;
					end else begin
						j_q     <= j_q + AW'(1);
						wn_q    <= wn_q + CNW'(1);
						state_q <= S_WCHK;
					end
				end
				S_WCHK: begin
					if (!r_used) begin
						state_q <= S_FIN;
					end else begin
						key_q   <= r_key;
						val_q   <= r_val;
						count_q <= count_dec;
						ph_q    <= PH_REPUT;
						state_q <= S_HASH1;
					end
				end
				S_FIN: begin
					// result waits here only while the previous beat is held
					if (!out_valid_q || !out_stall) begin
						out_data_q.status      <= st_q;
						out_data_q.value_out   <= vo_q;
						out_data_q.replaced    <= rp_q;
						out_data_q.entry_count <= 9'(count_q);
						state_q                <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

[hw/rtl/lph_chk.sv]
module lph_chk (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_stall,
	input lph_pkg::in_beat_t  in_data,
	input logic               out_valid,
	input logic               out_stall,
	input lph_pkg::out_beat_t out_data
);

	// held result beat stays put
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("result beat changed while stalled");

	// one operation at a time
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("beat accepted while busy");

	a_repl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.replaced |-> out_data.status == lph_pkg::STAT_DONE)
		else $error("replaced flag without success");

	a_value: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_data.value_out != '0) |->
			out_data.status == lph_pkg::STAT_DONE && !out_data.replaced)
		else $error("value returned on a failed or insert beat");

endmodule

bind linear_probe_hash_table_unit lph_chk u_lph_chk (.*);

[sim/linear_probe_hash_table_unit_tb.sv]
`timescale 1ns / 1ps

module linear_probe_hash_table_unit_tb;

	localparam int N_SLOTS   = 256;
	localparam int IDLE_LIMIT = 2000000;
	localparam logic [1:0] MODE_UNUSED = 2'd3;

	logic      clk;
	logic      arst_n;
	logic      in_valid;
	logic      in_stall;
	lph_pkg::in_beat_t  in_data;
	logic      out_valid;
	logic      out_stall;
	lph_pkg::out_beat_t out_data;

	linear_probe_hash_table_unit dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
	);

	// shadow table state
	logic [31:0] tbl_key [N_SLOTS];
	logic [31:0] tbl_val [N_SLOTS];
	logic        tbl_used [N_SLOTS];
	int unsigned tbl_count;

	lph_pkg::out_beat_t pending_results [$];
	int          error_count;
	int          idle_cycles;
	bit          stall_quiet;   // no random stall on the result side
	logic [31:0] known_keys [$];   // keys inserted so far, for hits

	initial clk = 1'b0;

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic logic [31:0] mix_hash(input logic [31:0] k);
		logic [31:0] x;
		x = k;
		x = (x ^ (x >> 16)) * 32'h045d_9f3b;
		x = (x ^ (x >> 16)) * 32'h045d_9f3b;
		return x ^ (x >> 16);
	endfunction

	function automatic int find_slot(input logic [31:0] k);
		int idx;
		idx = int'(mix_hash(k) & (N_SLOTS - 1));
		for (int n = 0; n < N_SLOTS; n++) begin
			if (!tbl_used[idx]) return -1;
			if (tbl_key[idx] == k) return idx;
			idx = (idx + 1) % N_SLOTS;
		end
		return -1;
	endfunction

	// store key/value; returns 1 when an existing key was overwritten
	function automatic bit place_entry(input logic [31:0] k, input logic [31:0] v);
		int idx;
		idx = int'(mix_hash(k) & (N_SLOTS - 1));
		for (int n = 0; n < N_SLOTS; n++) begin
			if (!tbl_used[idx]) break;
			if (tbl_key[idx] == k) begin
				tbl_val[idx] = v;
				return 1'b1;
			end
			idx = (idx + 1) % N_SLOTS;
		end
		if (!tbl_used[idx]) begin
			tbl_used[idx] = 1'b1;
			tbl_key[idx]  = k;
			tbl_val[idx]  = v;
			tbl_count++;
		end
		return 1'b0;
	endfunction

	function automatic lph_pkg::out_beat_t table_outcome(input lph_pkg::in_beat_t b);
		lph_pkg::out_beat_t r;
		int at, j;
		logic [31:0] k, v;
		bit dummy;
		r = '0;
		r.status = lph_pkg::STAT_NOTFOUND;
		if (b.mode == lph_pkg::MODE_INSERT) begin
			if (tbl_count >= N_SLOTS) r.status = lph_pkg::STAT_FULL;
			else begin
				r.replaced = place_entry(b.key, b.value_in);
				r.status = lph_pkg::STAT_DONE;
			end
		end else if (b.mode == lph_pkg::MODE_LOOKUP) begin
			at = find_slot(b.key);
			if (at >= 0) begin
				r.value_out = tbl_val[at];
				r.status = lph_pkg::STAT_DONE;
			end
		end else if (b.mode == lph_pkg::MODE_REMOVE) begin
			at = find_slot(b.key);
			if (at >= 0) begin
				tbl_used[at] = 1'b0;
				tbl_val[at] = '0;
				if (tbl_count > 0) tbl_count--;
				j = at;
				// re-place the rest of the cluster
				for (int n = 1; n < N_SLOTS; n++) begin
					j = (j + 1) % N_SLOTS;
					if (!tbl_used[j]) break;
					k = tbl_key[j];
					v = tbl_val[j];
					tbl_used[j] = 1'b0;
					if (tbl_count > 0) tbl_count--;
					dummy = place_entry(k, v);
				end
				r.status = lph_pkg::STAT_DONE;
			end
		end
		r.entry_count = tbl_count[8:0];
		return r;
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("mismatch %s: got %0h expected %0h", what, got, want);
		error_count++;
	endtask

	function automatic int pick_gap();
		if ($urandom_range(0, 3) != 0) return 0;
		if ($urandom_range(0, 9) == 0) return $urandom_range(10, 40);
		return $urandom_range(1, 3);
	endfunction

	// send one beat and record its expected result
	task automatic send_op(input logic [1:0] m, input logic [31:0] k,
			input logic [31:0] v);
		lph_pkg::in_beat_t b;
		int gap;
		gap = pick_gap();
		if (gap != 0) begin
			in_valid <= 1'b0;
			in_data  <= '0;
			repeat (gap) @(posedge clk);
		end
		b.mode = m;
		b.key = k;
		b.value_in = v;
		in_valid <= 1'b1;
		in_data  <= b;
		do @(posedge clk); while (in_stall);
		pending_results.push_back(table_outcome(b));
		if (m == lph_pkg::MODE_INSERT) known_keys.push_back(k);
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		in_data  <= '0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	function automatic logic [31:0] pick_key();
		if (known_keys.size() != 0 && $urandom_range(0, 2) != 0)
			return known_keys[$urandom_range(0, known_keys.size() - 1)];
		if ($urandom_range(0, 1) != 0) return $urandom_range(0, 600);
		return $urandom();
	endfunction

	// result side: stall at random and check every beat
	always @(posedge clk) begin
		lph_pkg::out_beat_t want;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (pending_results.size() == 0) begin
					$display("unexpected result beat %0h", out_data);
					error_count++;
				end else begin
					want = pending_results.pop_front();
					if (out_data.status !== want.status)
						report_mismatch("status", 32'(out_data.status), 32'(want.status));
					if (out_data.value_out !== want.value_out)
						report_mismatch("value_out", out_data.value_out, want.value_out);
					if (out_data.replaced !== want.replaced)
						report_mismatch("replaced", 32'(out_data.replaced),
							32'(want.replaced));
					if (out_data.entry_count !== want.entry_count)
						report_mismatch("entry_count", 32'(out_data.entry_count),
							32'(want.entry_count));
				end
			end
			out_stall <= stall_quiet ? 1'b0 : ($urandom_range(0, 3) == 0);
		end
	end

	// watchdog on cycles without any accepted beat
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("linear_probe_hash_table_unit verification failed");
			$finish;
		end
	end

	task automatic test_edges();
		send_op(lph_pkg::MODE_LOOKUP, 32'h0, 32'h0);           // lookup in empty table
		send_op(lph_pkg::MODE_REMOVE, 32'hffff_ffff, 32'h0);   // remove absent key
		send_op(lph_pkg::MODE_INSERT, 32'h0, 32'hffff_ffff);
		send_op(lph_pkg::MODE_INSERT, 32'hffff_ffff, 32'h0);
		send_op(lph_pkg::MODE_INSERT, 32'h0, 32'h1234_5678);   // replace
		send_op(lph_pkg::MODE_LOOKUP, 32'h0, 32'hffff_ffff);
		send_op(lph_pkg::MODE_LOOKUP, 32'hffff_ffff, 32'h0);
		send_op(MODE_UNUSED, 32'h0, 32'hffff_ffff);            // unused mode
		send_op(lph_pkg::MODE_REMOVE, 32'h0, 32'h0);
		send_op(lph_pkg::MODE_LOOKUP, 32'h0, 32'h0);
		send_op(lph_pkg::MODE_REMOVE, 32'hffff_ffff, 32'h0);
	endtask

	// fill until full, probe the full table, then empty it again
	task automatic test_full_table();
		logic [31:0] k;
		while (tbl_count < N_SLOTS) begin
			k = $urandom();
			send_op(lph_pkg::MODE_INSERT, k, $urandom());
		end
		send_op(lph_pkg::MODE_INSERT, known_keys[known_keys.size() - 1], 32'h5a5a_5a5a);
		send_op(lph_pkg::MODE_INSERT, 32'hdead_beef, 32'h1);
		send_op(lph_pkg::MODE_LOOKUP, 32'hdead_beef, 32'h0);   // full scan, absent
		send_op(lph_pkg::MODE_LOOKUP, known_keys[known_keys.size() - 1], 32'h0);
		// drain: let every result come before going on
		drain_results();
		for (int i = 0; i < known_keys.size(); i++)
			send_op(lph_pkg::MODE_REMOVE, known_keys[i], 32'h0);
		known_keys.delete();
	endtask

	task automatic test_random_mix(input int count);
		logic [1:0] m;
		int r;
		for (int i = 0; i < count; i++) begin
			r = $urandom_range(0, 19);
			if (r < 8) m = lph_pkg::MODE_INSERT;
			else if (r < 13) m = lph_pkg::MODE_LOOKUP;
			else if (r < 19) m = lph_pkg::MODE_REMOVE;
			else m = MODE_UNUSED;
			if (i % 200 == 100) stall_quiet = 1'b1;
			if (i % 200 == 150) stall_quiet = 1'b0;
			send_op(m, pick_key(), $urandom());
		end
	endtask

	initial begin
		error_count = 0;
		stall_quiet = 1'b0;
		tbl_count = 0;
		for (int i = 0; i < N_SLOTS; i++) begin
			tbl_used[i] = 1'b0;
			tbl_key[i] = '0;
			tbl_val[i] = '0;
		end
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		out_stall = 1'b0;
		idle_cycles = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		test_edges();
		test_full_table();
		test_random_mix(420);
		drain_results();
		if (error_count == 0)
			$display("linear_probe_hash_table_unit verification clean");
		else
			$display("linear_probe_hash_table_unit verification failed");
		$finish;
	end

endmodule
